// ===== rtl/assert_macros.svh =====
// assertion macros included by clebsch_gordan_coefficient.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define CG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// clocked assertion that also holds during reset
`define CG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cg_pkg.sv =====
// types, constants and the factorial table of the clebsch-gordan unit
`timescale 1ns / 1ps
`default_nettype none
package cg_pkg;

    localparam int NLIMB = 12;
    localparam int BW    = 32 * NLIMB;
    localparam int FACT_COUNT = 20;

    localparam logic [63:0] FACT_TABLE [FACT_COUNT] = '{
        64'd1, 64'd1, 64'd2, 64'd6, 64'd24, 64'd120, 64'd720, 64'd5040, 64'd40320,
        64'd362880, 64'd3628800, 64'd39916800, 64'd479001600, 64'd6227020800,
        64'd87178291200, 64'd1307674368000, 64'd20922789888000,
        64'd355687428096000, 64'd6402373705728000, 64'd121645100408832000
    };

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_LOAD = 10'b0000000010,
        S_KCHK = 10'b0000000100,
        S_MUL  = 10'b0000001000,
        S_DIV  = 10'b0000010000,
        S_SRCH = 10'b0000100000,
        S_CMP  = 10'b0001000000,
        S_OUT  = 10'b0010000000,
        S_SPR1 = 10'b0100000000,
        S_SPR2 = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        JOB_K   = 2'd0,
        JOB_NUM = 2'd1,
        JOB_DEN = 2'd2,
        JOB_SQ  = 2'd3
    } t_job;

    // factorial, one for negative arguments, clamped at the table end
    function automatic logic [63:0] fact_of(input logic signed [6:0] i);
        logic [63:0] r;
        if (i < 0) begin
            r = 64'd1;
        end else if (i >= 7'sd19) begin
            r = FACT_TABLE[FACT_COUNT - 1];
        end else begin
            r = FACT_TABLE[i[4:0]];
        end
        return r;
    endfunction

    // number of multiplications in each job
    function automatic logic [3:0] job_len(input t_job j);
        logic [3:0] r;
        unique case (j)
            JOB_K:   r = 4'd5;
            JOB_NUM: r = 4'd11;
            JOB_DEN: r = 4'd2;
            JOB_SQ:  r = 4'd2;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/clebsch_gordan_coefficient.sv =====
// clebsch-gordan coefficient unit, racah formula on a shared limb multiplier
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One item at a time: o_ready is high only while idle. An item with failing argument
// checks or a projection mismatch goes from the load state straight to the output state.
// Otherwise the work is done by a single 32x32 limb multiplier on a 384-bit accumulator
// (two passes over its limbs per 64-bit factor) and a one-bit-per-cycle 64-bit divider:
// per racah term 5 multiplications and a division, then 13 multiplications for the squared
// prefactor, then FRACTION_BITS+1 search steps of two multiplications each. The result
// waits in an output register, so a new item can be taken while it is pending.
module clebsch_gordan_coefficient
    import cg_pkg::*;
#(
    parameter int MAX_TWICE_SPIN = 12,
    parameter int FRACTION_BITS  = 30
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire        [3:0]  i_twice_spin_a,
    input  wire        [3:0]  i_twice_spin_b,
    input  wire        [3:0]  i_twice_spin_total,
    input  wire signed [4:0]  i_twice_proj_a,
    input  wire signed [4:0]  i_twice_proj_b,
    input  wire signed [4:0]  i_twice_proj_total,
    output logic              o_valid,
    input  wire               i_ready,
    output logic signed [31:0] o_coefficient,
    output logic              o_arguments_valid
);

    localparam int SW = FRACTION_BITS + 2;
    localparam int NSH = 2 * FRACTION_BITS + 2;
    localparam logic [6:0] MAXJ = 7'(MAX_TWICE_SPIN);

    t_state r_state;
    t_job   r_job;
    logic [3:0] r_step, r_limb, r_k;
    logic       r_pass;
    logic [BW-1:0] r_x, r_y, r_res, r_num, r_den;
    logic [33:0] r_carry;
    logic [63:0] r_q, r_dv;
    logic [64:0] r_rem;
    logic [5:0]  r_dcnt;
    logic signed [63:0] r_sum;
    logic [SW-1:0] r_lo, r_hi, r_mid;
    logic signed [6:0] r_j1, r_j2, r_jt, r_m1, r_m2, r_mt;
    logic signed [6:0] r_c, r_a, r_b, r_d, r_e, r_s;
    logic        r_args_ok;
    logic        r_wok;
    logic        r_ovalid;
    logic signed [31:0] r_coef;
    logic signed [31:0] r_wcoef;

    // argument checks and racah indices from the latched item
    logic args_ok, proj_match;
    logic signed [6:0] ks;
    logic [63:0] mag;
    always_comb begin
        args_ok = 1'b1;
        if (r_j1 > $signed(MAXJ) || r_j2 > $signed(MAXJ) || r_jt > $signed(MAXJ))
            args_ok = 1'b0;
        if (r_m1 > r_j1 || -r_m1 > r_j1 || r_m2 > r_j2 || -r_m2 > r_j2
            || r_mt > r_jt || -r_mt > r_jt)
            args_ok = 1'b0;
        if (r_j1[0] ^ r_m1[0] || r_j2[0] ^ r_m2[0] || r_jt[0] ^ r_mt[0])
            args_ok = 1'b0;
        if (r_j1[0] ^ r_j2[0] ^ r_jt[0] || r_jt > r_j1 + r_j2)
            args_ok = 1'b0;
        if (r_j1 - r_j2 > r_jt || r_j2 - r_j1 > r_jt)
            args_ok = 1'b0;
        proj_match = (r_mt == r_m1 + r_m2);
        ks = $signed({3'b000, r_k});
        mag = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
    end

    // factor for the current multiplication
    logic [63:0] factor;
    always_comb begin
        factor = 64'd1;
        unique case (r_job)
            JOB_K: begin
                case (r_step)
                    4'd0: factor = fact_of(r_c - ks);
                    4'd1: factor = fact_of(r_a - ks);
                    4'd2: factor = fact_of(r_b - ks);
                    4'd3: factor = fact_of(r_d + ks);
                    default: factor = fact_of(r_e + ks);
                endcase
            end
            JOB_NUM: begin
                case (r_step)
                    4'd0: factor = fact_of(r_c);
                    4'd1: factor = fact_of((r_jt - r_j1 + r_j2) >>> 1);
                    4'd2: factor = fact_of((r_jt + r_j1 - r_j2) >>> 1);
                    4'd3: factor = fact_of((r_jt + r_mt) >>> 1);
                    4'd4: factor = fact_of((r_jt - r_mt) >>> 1);
                    4'd5: factor = fact_of(r_a);
                    4'd6: factor = fact_of((r_j1 + r_m1) >>> 1);
                    4'd7: factor = fact_of((r_j2 - r_m2) >>> 1);
                    4'd8: factor = fact_of(r_b);
                    default: factor = mag;
                endcase
            end
            JOB_DEN: factor = fact_of(r_s);
            JOB_SQ:  factor = (64'(r_mid) << 1) - 64'd1;
            default: factor = 64'd1;
        endcase
    end

    // shared limb multiply-accumulate
    logic [31:0] mul_m, mul_y;
    logic [65:0] mul_t;
    logic [BW-1:0] n_res;
    always_comb begin
        mul_m = r_pass ? factor[31:0] : factor[63:32];
        mul_y = r_pass ? r_y[31:0] : 32'd0;
        mul_t = 66'({32'd0, r_x[31:0]} * {32'd0, mul_m}) + 66'(mul_y) + 66'(r_carry);
        n_res = {mul_t[31:0], r_res[BW-1:32]};
    end

    // divider step and search midpoint
    logic [64:0] n_rem;
    logic [SW-1:0] n_mid;
    always_comb begin
        n_rem = {r_rem[63:0], r_q[63]};
        n_mid = r_lo + ((r_hi - r_lo) >> 1);
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_coefficient = r_coef;
    assign o_arguments_valid = r_args_ok;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_j1 <= $signed({3'b000, i_twice_spin_a});
                        r_j2 <= $signed({3'b000, i_twice_spin_b});
                        r_jt <= $signed({3'b000, i_twice_spin_total});
                        r_m1 <= 7'(i_twice_proj_a);
                        r_m2 <= 7'(i_twice_proj_b);
                        r_mt <= 7'(i_twice_proj_total);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_wok <= args_ok;
                    r_c <= (r_j1 + r_j2 - r_jt) >>> 1;
                    r_a <= (r_j1 - r_m1) >>> 1;
                    r_b <= (r_j2 + r_m2) >>> 1;
                    r_d <= (r_jt - r_j2 + r_m1) >>> 1;
                    r_e <= (r_jt - r_j1 - r_m2) >>> 1;
                    r_s <= (r_j1 + r_j2 + r_jt) >>> 1;
                    r_k <= 4'd0;
                    r_sum <= '0;
                    r_wcoef <= '0;
                    if (!args_ok || !proj_match) r_state <= S_OUT;
                    else r_state <= S_KCHK;
                end
                S_KCHK: begin
                    r_step <= 4'd0;
                    r_pass <= 1'b0;
                    r_limb <= 4'd0;
                    r_carry <= '0;
                    if (ks > r_c) begin
                        if (r_sum == 0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_x <= BW'(r_jt + 7'sd1);
                            r_job <= JOB_NUM;
                            r_state <= S_MUL;
                        end
                    end else if (r_a - ks < 0 || r_b - ks < 0 || r_d + ks < 0
                                 || r_e + ks < 0) begin
                        r_k <= r_k + 4'd1;
                    end else begin
                        r_x <= BW'(fact_of(ks));
                        r_job <= JOB_K;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_res <= n_res;
                    if (r_limb != 4'(NLIMB - 1)) begin
                        r_x <= {r_x[31:0], r_x[BW-1:32]};
                        r_y <= r_y >> 32;
                        r_carry <= mul_t[65:32];
                        r_limb <= r_limb + 4'd1;
                    end else begin
                        r_limb <= 4'd0;
                        r_carry <= '0;
                        if (!r_pass) begin
                            // high half done, low half adds it one limb up
                            r_x <= {r_x[31:0], r_x[BW-1:32]};
                            r_y <= n_res << 32;
                            r_pass <= 1'b1;
                        end else begin
                            r_pass <= 1'b0;
                            if (r_step + 4'd1 == job_len(r_job)) begin
                                r_step <= 4'd0;
                                unique case (r_job)
                                    JOB_K: begin
                                        r_x <= n_res;
                                        r_dv <= n_res[63:0];
                                        r_q <= fact_of(r_s);
                                        r_rem <= '0;
                                        r_dcnt <= '0;
                                        r_state <= S_DIV;
                                    end
                                    JOB_NUM: begin
                                        r_num <= n_res << NSH;
                                        r_x <= BW'(fact_of(r_s + 7'sd1));
                                        r_job <= JOB_DEN;
                                    end
                                    JOB_DEN: begin
                                        r_x <= n_res;
                                        r_den <= n_res;
                                        r_lo <= '0;
                                        r_hi <= (SW'(1) << FRACTION_BITS) + SW'(1);
                                        r_state <= S_SRCH;
                                    end
                                    JOB_SQ: begin
                                        r_x <= n_res;
                                        r_state <= S_CMP;
                                    end
                                    default: begin
                                        r_x <= n_res;
                                        r_state <= S_CMP;
                                    end
                                endcase
                            end else begin
                                r_x <= n_res;
                                r_step <= r_step + 4'd1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (n_rem >= {1'b0, r_dv}) begin
                        r_rem <= n_rem - {1'b0, r_dv};
                        r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_q <= {r_q[62:0], 1'b0};
                    end
                    if (r_dcnt == 6'd63) r_state <= S_SPR1;
                end
                S_SPR1: begin
                    // fold the quotient into the alternating sum
                    if (r_k[0]) r_sum <= r_sum - $signed(r_q);
                    else r_sum <= r_sum + $signed(r_q);
                    r_k <= r_k + 4'd1;
                    r_state <= S_KCHK;
                end
                S_SRCH: begin
                    r_pass <= 1'b0;
                    r_limb <= 4'd0;
                    r_carry <= '0;
                    r_step <= 4'd0;
                    if (r_hi - r_lo > SW'(1)) begin
                        r_mid <= n_mid;
                        r_x <= r_den;
                        r_job <= JOB_SQ;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_SPR2;
                    end
                end
                S_CMP: begin
                    if (r_x <= r_num) r_lo <= r_mid;
                    else r_hi <= r_mid;
                    r_state <= S_SRCH;
                end
                S_SPR2: begin
                    r_wcoef <= r_sum[63] ? -32'(64'(r_lo)) : 32'(64'(r_lo));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hand the result to the output register once it is free
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_coef <= r_wcoef;
                        r_args_ok <= r_wok;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CG_ASSERT(a_invalid_zero, i_clk, i_rst_n, o_valid && !o_arguments_valid |-> o_coefficient == 0, "invalid arguments with nonzero coefficient")
    `CG_ASSERT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "ready right after a transfer")
    `CG_ASSERT(a_limb_range, i_clk, i_rst_n, r_state == S_MUL |-> r_limb < 4'(NLIMB), "limb counter out of range")

endmodule
`default_nettype wire
